@@ rtl/latency_histogram_percentiles_top_macros.svh @@
// assertion macros for the latency histogram block
`ifndef LATENCY_HISTOGRAM_PERCENTILES_TOP_MACROS_SVH
`define LATENCY_HISTOGRAM_PERCENTILES_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define LHP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lhp_pkg.sv @@
// shared constants, types and functions for the latency histogram block
`timescale 1ns / 1ps
`default_nettype none

package lhp_pkg;

    localparam int unsigned BIN_COUNT       = 128;
    localparam int unsigned FINE_BINS       = 64;
    localparam int unsigned FINE_WIDTH_NS   = 1024;
    localparam int unsigned COARSE_WIDTH_NS = 65536;

    localparam int unsigned BIN_AW    = $clog2(BIN_COUNT);
    localparam int unsigned PCT_NUM   = 3;
    localparam int unsigned PCT_SCALE = 100;
    localparam int unsigned SUM_W     = 32 + 7 + BIN_AW + 1;

    localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;
    localparam logic [32:0] FINE_SPAN_NS = 33'(FINE_BINS * FINE_WIDTH_NS);

    typedef logic [BIN_AW-1:0] bin_idx_t;
    typedef logic [SUM_W-1:0]  sum_t;

    localparam bin_idx_t BIN_LAST = BIN_AW'(BIN_COUNT - 1);

    localparam logic [6:0] PCT_VAL [PCT_NUM] = '{7'd50, 7'd95, 7'd99};

    typedef struct packed {
        logic     start;
        logic     step;
        bin_idx_t idx;
    } scan_ctl_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == MAX32) ? v : v + 32'd1;
    endfunction

    function automatic bin_idx_t bin_of(input logic [31:0] ns);
        logic [32:0] q;
        if (33'(ns) < FINE_SPAN_NS)
        begin
            q = 33'(ns / FINE_WIDTH_NS);
        end
        else
        begin
            q = 33'(FINE_BINS) + 33'((33'(ns) - FINE_SPAN_NS) / COARSE_WIDTH_NS);
        end
        if (q > 33'(BIN_COUNT - 1))
        begin
            q = 33'(BIN_COUNT - 1);
        end
        return q[BIN_AW-1:0];
    endfunction

    function automatic logic [31:0] bin_edge(input bin_idx_t idx);
        logic [63:0] e;
        if (32'(idx) < FINE_BINS)
        begin
            e = (64'(idx) + 64'd1) * 64'(FINE_WIDTH_NS);
        end
        else
        begin
            e = 64'(FINE_SPAN_NS)
                + (64'(idx) - 64'(FINE_BINS) + 64'd1) * 64'(COARSE_WIDTH_NS);
        end
        return (e > 64'(MAX32)) ? MAX32 : e[31:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/lhp_bin_ram.sv @@
// bin count memory with per-entry valid bits and registered read
`timescale 1ns / 1ps
`default_nettype none

module lhp_bin_ram (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lhp_pkg::bin_idx_t rd_addr,
    input  wire logic              wr_en,
    input  wire lhp_pkg::bin_idx_t wr_addr,
    input  wire logic [31:0]       wr_data,
    output logic [31:0]            rd_data
);

    logic [31:0]                     mem [lhp_pkg::BIN_COUNT];
    logic [lhp_pkg::BIN_COUNT-1:0]   vld_reg;
    logic [31:0]                     rd_raw_reg;
    logic                            rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= mem[rd_addr];
        rd_vld_reg <= vld_reg[rd_addr];
    end

    // never-written entries read as zero
    assign rd_data = rd_vld_reg ? rd_raw_reg : 32'd0;

endmodule

`default_nettype wire

@@ rtl/lhp_pct_scan.sv @@
// running-sum percentile scan over the bin counts
`timescale 1ns / 1ps
`default_nettype none

module lhp_pct_scan (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lhp_pkg::scan_ctl_t   ctl,
    input  wire logic [31:0]          total,
    input  wire logic [31:0]          peak,
    input  wire logic [31:0]          rd_data,
    output logic [lhp_pkg::PCT_NUM-1:0][31:0] pct_ns
);

    lhp_pkg::sum_t                   acc_reg;
    lhp_pkg::sum_t                   acc_next;
    lhp_pkg::sum_t                   tgt_reg [lhp_pkg::PCT_NUM];
    logic [lhp_pkg::PCT_NUM-1:0]     found_reg;
    logic [lhp_pkg::PCT_NUM-1:0]     hit;
    logic [31:0]                     pct_reg [lhp_pkg::PCT_NUM];
    logic [31:0]                     edge_val;

    // compare sum*100 against total*p, same as sum >= ceil(total*p/100)
    assign acc_next = acc_reg
                      + lhp_pkg::SUM_W'(rd_data) * lhp_pkg::SUM_W'(lhp_pkg::PCT_SCALE);
    assign edge_val = (ctl.idx == lhp_pkg::BIN_LAST) ? peak : lhp_pkg::bin_edge(ctl.idx);

    always_comb
    begin
        for (int k = 0; k < lhp_pkg::PCT_NUM; k++)
        begin
            hit[k] = !found_reg[k] && (acc_next >= tgt_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            found_reg <= '0;
        end
        else if (ctl.start)
        begin
            acc_reg   <= '0;
            found_reg <= '0;
        end
        else if (ctl.step)
        begin
            acc_reg   <= acc_next;
            found_reg <= found_reg | hit;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < lhp_pkg::PCT_NUM; k++)
        begin
            if (ctl.start)
            begin
                tgt_reg[k] <= lhp_pkg::SUM_W'(total) * lhp_pkg::SUM_W'(lhp_pkg::PCT_VAL[k]);
            end
            else if (ctl.step && hit[k])
            begin
                pct_reg[k] <= edge_val;
            end
        end
    end

    // rank never reached falls back to the maximum
    always_comb
    begin
        for (int k = 0; k < lhp_pkg::PCT_NUM; k++)
        begin
            pct_ns[k] = found_reg[k] ? pct_reg[k] : peak;
        end
    end

endmodule

`default_nettype wire

@@ rtl/latency_histogram_percentiles_top.sv @@
// latency histogram with percentile summary, top level
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | into      | in_valid, in_stall | req_type, latency_ns
//   out     | out of    | out_valid,out_stall| total_samples, max_ns, p50/p95/p99_ns
//
// a record transaction reads the bin count, then does the saturating write-back in S_REC_WR
// a query transaction walks all 128 bins through the memory read port, one per cycle;
// its result is loaded into the output registers from S_DONE, then the next transaction can be accepted
// reset clears every bin through per-entry valid bits, no clearing pass is needed
// a pending result does not block input; a finished query waits in S_DONE while an earlier result is held by out_stall
`timescale 1ns / 1ps
`default_nettype none

`include "latency_histogram_percentiles_top_macros.svh"

module latency_histogram_percentiles_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [31:0] latency_ns,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      total_samples,
    output logic [31:0]      max_ns,
    output logic [31:0]      p50_ns,
    output logic [31:0]      p95_ns,
    output logic [31:0]      p99_ns
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REC_WR = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    logic [1:0]          state_reg, state_next;
    logic [31:0]         sample_total_reg;
    logic [31:0]         peak_reg;
    lhp_pkg::bin_idx_t   bin_reg;
    lhp_pkg::bin_idx_t   walk_idx_reg;
    lhp_pkg::bin_idx_t   rd_addr;
    logic                wr_en;
    logic [31:0]         rd_data;
    logic                in_xact;
    logic                out_load;
    lhp_pkg::scan_ctl_t  scan_ctl;
    logic [lhp_pkg::PCT_NUM-1:0][31:0] pct_ns;

    logic                out_valid_reg;
    logic [31:0]         out_total_reg;
    logic [31:0]         out_max_reg;
    logic [31:0]         out_p50_reg;
    logic [31:0]         out_p95_reg;
    logic [31:0]         out_p99_reg;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xact  = in_valid && !in_stall;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign wr_en    = (state_reg == S_REC_WR);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = (req_type == REQ_QUERY) ? '0 : lhp_pkg::bin_of(latency_ns);
            S_WALK:  rd_addr = walk_idx_reg + lhp_pkg::BIN_AW'(1);
            S_REC_WR,
            S_DONE:  rd_addr = bin_reg;
            default: rd_addr = bin_reg;
        endcase
    end

    always_comb
    begin
        scan_ctl.start = in_xact && (req_type == REQ_QUERY);
        scan_ctl.step  = (state_reg == S_WALK);
        scan_ctl.idx   = walk_idx_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xact)
                begin
                    state_next = (req_type == REQ_QUERY) ? S_WALK : S_REC_WR;
                end
            end
            S_REC_WR: state_next = S_IDLE;
            S_WALK:
            begin
                if (walk_idx_reg == lhp_pkg::BIN_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sample_total_reg <= '0;
            peak_reg         <= '0;
            walk_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xact && (req_type == REQ_RECORD))
            begin
                sample_total_reg <= lhp_pkg::sat_inc(sample_total_reg);
                if (latency_ns > peak_reg)
                begin
                    peak_reg <= latency_ns;
                end
            end
            if (scan_ctl.start)
            begin
                walk_idx_reg <= '0;
            end
            else if (state_reg == S_WALK)
            begin
                walk_idx_reg <= walk_idx_reg + lhp_pkg::BIN_AW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xact && (req_type == REQ_RECORD))
        begin
            bin_reg <= rd_addr;
        end
        if (out_load)
        begin
            out_total_reg <= sample_total_reg;
            out_max_reg   <= peak_reg;
            // empty histogram reports zero estimates
            out_p50_reg   <= (sample_total_reg == 32'd0) ? 32'd0 : pct_ns[0];
            out_p95_reg   <= (sample_total_reg == 32'd0) ? 32'd0 : pct_ns[1];
            out_p99_reg   <= (sample_total_reg == 32'd0) ? 32'd0 : pct_ns[2];
        end
    end

    lhp_bin_ram u_bin_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (bin_reg),
        .wr_data (lhp_pkg::sat_inc(rd_data)),
        .rd_data (rd_data)
    );

    lhp_pct_scan u_pct_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .total   (sample_total_reg),
        .peak    (peak_reg),
        .rd_data (rd_data),
        .pct_ns  (pct_ns)
    );

    assign out_valid     = out_valid_reg;
    assign total_samples = out_total_reg;
    assign max_ns        = out_max_reg;
    assign p50_ns        = out_p50_reg;
    assign p95_ns        = out_p95_reg;
    assign p99_ns        = out_p99_reg;

    `LHP_ASSERT_NEXT(a_rec_writes_back, clk, rst_n, in_xact && (req_type == REQ_RECORD), wr_en, "record transaction not written back")
    `LHP_ASSERT_NEXT(a_query_walks, clk, rst_n, in_xact && (req_type == REQ_QUERY), (state_reg == S_WALK) && (walk_idx_reg == '0), "query walk did not start at bin zero")
    `LHP_ASSERT_SAME(a_out_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_DONE, "result raised outside query completion")
    `LHP_ASSERT_NEXT(a_total_monotonic, clk, rst_n, 1'b1, sample_total_reg >= $past(sample_total_reg), "sample total decreased")

endmodule

`default_nettype wire
